### rtl/core/lcft_pkg.sv
// lcft_pkg: shared types for the led cube frame transform core
// command codes, controller states and the control/status structs
// no dependencies
`default_nettype none

package lcft_pkg;

  typedef enum logic [3:0] {
    CMD_WRITE    = 4'd0,
    CMD_READ     = 4'd1,
    CMD_FILL     = 4'd2,
    CMD_FWD      = 4'd3,
    CMD_BACK     = 4'd4,
    CMD_DOWN     = 4'd5,
    CMD_UP       = 4'd6,
    CMD_BITLEFT  = 4'd7,
    CMD_BITRIGHT = 4'd8,
    CMD_ROTATE   = 4'd9
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic apply;    // carry out the latched request
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;  // latched request returns a byte
  } status_t;

endpackage

`default_nettype wire

### rtl/core/lcft_ctrl.sv
// lcft_ctrl: two-state controller of the frame transform core
// depends on lcft_pkg
`default_nettype none

module lcft_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire lcft_pkg::status_t status,
  output lcft_pkg::ctrl_t       ctrl,
  output logic                  busy,
  output logic                  done
);
  import lcft_pkg::*;

  state_t state, state_next;
  logic   done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next   = state;
    done_next    = 1'b0;
    ctrl.capture = 1'b0;
    ctrl.apply   = 1'b0;
    busy         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          ctrl.capture = 1'b1;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy        = 1'b1;
        ctrl.apply  = 1'b1;
        done_next   = status.is_read;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/lcft_datapath.sv
// lcft_datapath: 64-byte cube frame register and its transforms
// request latch, read register, shift and ring rotation logic
// depends on lcft_pkg
`default_nettype none

module lcft_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lcft_pkg::ctrl_t ctrl,
  input  wire logic [3:0]      cmd,
  input  wire logic [5:0]      byte_address,
  input  wire logic [7:0]      byte_value,
  input  wire logic [7:0]      rotate_step,
  output lcft_pkg::status_t    status,
  output logic [7:0]           read_value
);
  import lcft_pkg::*;

  typedef logic [63:0][7:0] frame_t;

  // rings that move for a given tick; 8 = 1 mod 7, so octal digits add up
  function automatic logic [3:0] ring_moves(input logic [7:0] step);
    logic [4:0] s;
    logic [3:0] t;
    logic [2:0] p;
    logic [3:0] m;
    s = {2'b0, step[2:0]} + {2'b0, step[5:3]} + {3'b0, step[7:6]};
    t = {1'b0, s[2:0]} + {2'b0, s[4:3]};
    p = (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
    case (p) inside
      3'd4:       m = 4'b1111;
      3'd2, 3'd6: m = 4'b0111;
      3'd3, 3'd5: m = 4'b0001;
      default:    m = 4'b0011;
    endcase
    return m;
  endfunction

  // one clockwise step of the selected rings of every layer
  function automatic frame_t rotate_frame(input frame_t c, input logic [3:0] mv);
    frame_t d;
    int     r, lo, hi;
    d = c;
    for (int l = 0; l < 8; l++) begin
      for (int y = 0; y < 8; y++) begin
        for (int x = 0; x < 8; x++) begin
          r = y;
          if (x < r) r = x;
          if (7 - y < r) r = 7 - y;
          if (7 - x < r) r = 7 - x;
          lo = r;
          hi = 7 - r;
          if (mv[r]) begin
            if (y == lo) begin
              if (x == lo) d[l*8+y][x] = c[l*8+y+1][x];
              else         d[l*8+y][x] = c[l*8+y][x-1];
            end else if (y == hi) begin
              if (x == hi) d[l*8+y][x] = c[l*8+y-1][x];
              else         d[l*8+y][x] = c[l*8+y][x+1];
            end else if (x == hi) begin
              d[l*8+y][x] = c[l*8+y-1][x];
            end else begin
              d[l*8+y][x] = c[l*8+y+1][x];
            end
          end
        end
      end
    end
    return d;
  endfunction

  frame_t     frame, frame_next;
  logic [3:0] req_cmd;
  logic [5:0] req_addr;
  logic [7:0] req_value;
  logic [3:0] req_moves;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      req_cmd   <= cmd;
      req_addr  <= byte_address;
      req_value <= byte_value;
      req_moves <= ring_moves(rotate_step);
    end
    if (ctrl.apply && req_cmd == CMD_READ) begin
      read_value <= frame[req_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
    end else if (ctrl.apply) begin
      frame <= frame_next;
    end
  end

  assign status.is_read = (req_cmd == CMD_READ);

  always_comb begin
    frame_next = frame;
    case (req_cmd)
      CMD_WRITE: frame_next[req_addr] = req_value;
      CMD_FILL: begin
        for (int i = 0; i < 64; i++) frame_next[i] = req_value;
      end
      CMD_FWD: begin
        for (int i = 0; i < 64; i++)
          frame_next[i] = (i % 8 == 7) ? 8'h00 : frame[i+1];
      end
      CMD_BACK: begin
        for (int i = 0; i < 64; i++)
          frame_next[i] = (i % 8 == 0) ? 8'h00 : frame[i-1];
      end
      CMD_DOWN: begin
        for (int i = 0; i < 64; i++)
          frame_next[i] = (i >= 56) ? 8'h00 : frame[i+8];
      end
      CMD_UP: begin
        for (int i = 0; i < 64; i++)
          frame_next[i] = (i < 8) ? 8'h00 : frame[i-8];
      end
      CMD_BITLEFT: begin
        for (int i = 0; i < 64; i++) frame_next[i] = {frame[i][6:0], 1'b0};
      end
      CMD_BITRIGHT: begin
        for (int i = 0; i < 64; i++) frame_next[i] = {1'b0, frame[i][7:1]};
      end
      CMD_ROTATE: frame_next = rotate_frame(frame, req_moves);
      default:    frame_next = frame;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/led_cube_frame_transform_core.sv
// led_cube_frame_transform_core: top level of the cube frame store
// joins the controller and the datapath; depends on lcft_pkg,
// lcft_ctrl and lcft_datapath
`default_nettype none

// usage
// - a request is taken at a rising edge where start is high and busy is
//   low; cmd, byte_address, byte_value and rotate_step are sampled there
// - each request is taken at its capture edge and carried out in the
//   execute cycle that follows, in which busy is high and the whole
//   512-bit frame is updated in a single step; no new request is taken
//   while busy is high, so a request is done before the next is taken
// - only a read returns a result: done rises at the edge that ends the
//   execute cycle and stays high for exactly one cycle, with read_value valid
//   alongside; the result is taken in that cycle
// - the receiver cannot stall; done is a pure strobe and is not held
// - writes, fills, shifts and rotations return nothing; unused command
//   codes leave the frame unchanged
// - rotation moves the rings chosen by rotate_step mod 7; rings that do
//   not move keep their bits
// - a synchronous reset clears the whole frame to zero, returns the
//   controller to idle and drops done

module led_cube_frame_transform_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [3:0] cmd,
  input  wire logic [5:0] byte_address,
  input  wire logic [7:0] byte_value,
  input  wire logic [7:0] rotate_step,
  output logic            done,
  output logic [7:0]      read_value
);
  import lcft_pkg::*;

  ctrl_t   ctrl;    // capture / apply commands
  status_t status;  // latched request is a read

  lcft_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy),
    .done   (done)
  );

  lcft_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .cmd          (cmd),
    .byte_address (byte_address),
    .byte_value   (byte_value),
    .rotate_step  (rotate_step),
    .status       (status),
    .read_value   (read_value)
  );

  // a taken request is always followed by an execute cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken without an execute cycle");

  // an execute cycle is never followed directly by another
  a_exec_single: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("execute cycle repeated");

  // a result strobe only follows an execute cycle
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without execute");

  // a result strobe only answers a read request
  a_done_is_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && cmd == CMD_READ, 2))
    else $error("result strobe for a request that is not a read");

endmodule

`default_nettype wire

### tb/tb_led_cube_frame_transform_core.sv
// tb_led_cube_frame_transform_core: self-checking bench for the cube frame store
// drives directed and random requests, predicts most read bytes from its own frame image
// depends on lcft_pkg and led_cube_frame_transform_core
`timescale 1ns / 1ps

module tb_led_cube_frame_transform_core;
  import lcft_pkg::*;

  // codes the block leaves alone
  localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  localparam int RING_PERIOD     = 7;
  localparam int RANDOM_REQUESTS = 750;
  localparam int QUIET_TAIL      = 120;   // last requests sent back to back
  localparam int DRAIN_CYCLES    = 4;     // read result lands after the execute cycle
  localparam int CYCLE_LIMIT     = 100000;

  typedef struct {
    logic [3:0] cmd;
    logic [5:0] byte_address;
    logic [7:0] byte_value;
    logic [7:0] rotate_step;
  } frame_request_t;

  typedef struct {
    frame_request_t req;
    bit             has_known;   // expected byte typed in by hand
    logic [7:0]     known_byte;
  } directed_row_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [3:0] cmd;
  logic [5:0] byte_address;
  logic [7:0] byte_value;
  logic [7:0] rotate_step;
  logic       done;
  logic [7:0] read_value;

  // own copy of the 64-byte frame, address is layer*8+row, bit is column
  logic [7:0] frame_image [64];
  logic [7:0] expected_read_bytes [$];
  int         mismatch_count;
  int         cycle_count;

  led_cube_frame_transform_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .byte_address (byte_address),
    .byte_value   (byte_value),
    .rotate_step  (rotate_step),
    .done         (done),
    .read_value   (read_value)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at cycle %0d: %s, got %02h want %02h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // bits lo_bit..hi_bit set
  function automatic logic [7:0] bit_run(input int lo_bit, input int hi_bit);
    logic [7:0] m;
    m = '0;
    for (int i = lo_bit; i <= hi_bit; i++) m[i] = 1'b1;
    return m;
  endfunction

  // how many rings, counted from the outside, turn for this tick
  function automatic int turning_rings(input logic [7:0] tick);
    int phase;
    phase = tick % RING_PERIOD;
    case (phase)
      4:       return 4;
      2, 6:    return 3;
      3, 5:    return 1;
      default: return 2;
    endcase
  endfunction

  // advance the frame image by one request; a read hands back its byte
  task automatic apply_frame_request(input frame_request_t req, output bit gives_byte,
                                     output logic [7:0] byte_out);
    logic [7:0] next_img [64];
    logic [7:0] lo_mask;
    logic [7:0] hi_mask;
    int         base;
    int         hi;
    int         rings;
    bit         transform;
    gives_byte = 1'b0;
    byte_out   = '0;
    transform  = 1'b1;
    foreach (next_img[i]) next_img[i] = '0;
    case (req.cmd)
      CMD_WRITE: begin
        frame_image[req.byte_address] = req.byte_value;
        transform = 1'b0;
      end
      CMD_READ: begin
        gives_byte = 1'b1;
        byte_out   = frame_image[req.byte_address];
        transform  = 1'b0;
      end
      CMD_FILL: begin
        foreach (frame_image[i]) frame_image[i] = req.byte_value;
        transform = 1'b0;
      end
      CMD_FWD: begin
        // row r takes row r+1, last row of each layer clears
        for (int a = 0; a < 64; a++) if (a % 8 != 7) next_img[a] = frame_image[a + 1];
      end
      CMD_BACK: begin
        for (int a = 0; a < 64; a++) if (a % 8 != 0) next_img[a] = frame_image[a - 1];
      end
      CMD_DOWN: begin
        for (int a = 0; a < 56; a++) next_img[a] = frame_image[a + 8];
      end
      CMD_UP: begin
        for (int a = 8; a < 64; a++) next_img[a] = frame_image[a - 8];
      end
      CMD_BITLEFT: begin
        foreach (frame_image[a]) next_img[a] = frame_image[a] << 1;
      end
      CMD_BITRIGHT: begin
        foreach (frame_image[a]) next_img[a] = frame_image[a] >> 1;
      end
      CMD_ROTATE: begin
        rings = turning_rings(req.rotate_step);
        for (int layer = 0; layer < 8; layer++) begin
          base = layer * 8;
          for (int r = 0; r < 4; r++) begin
            hi      = 7 - r;
            lo_mask = 8'(1 << r);
            hi_mask = 8'(1 << hi);
            if (r < rings) begin
              // clockwise: top row right, right column down, bottom row left, left column up
              next_img[base + r] |= ((frame_image[base + r] << 1) & bit_run(r + 1, hi))
                                    | (frame_image[base + r + 1] & lo_mask);
              next_img[base + hi] |= ((frame_image[base + hi] >> 1) & bit_run(r, hi - 1))
                                     | (frame_image[base + hi - 1] & hi_mask);
              for (int y = r + 1; y < hi; y++)
                next_img[base + y] |= (frame_image[base + y - 1] & hi_mask)
                                      | (frame_image[base + y + 1] & lo_mask);
            end else begin
              // a ring that stays put keeps its bits
              next_img[base + r]  |= frame_image[base + r] & bit_run(r, hi);
              next_img[base + hi] |= frame_image[base + hi] & bit_run(r, hi);
              for (int y = r + 1; y < hi; y++)
                next_img[base + y] |= frame_image[base + y] & (lo_mask | hi_mask);
            end
          end
        end
      end
      default: begin
        // unused code, frame untouched
        transform = 1'b0;
      end
    endcase
    if (transform) foreach (frame_image[a]) frame_image[a] = next_img[a];
  endtask

  // present a request and hold it until the block takes it
  task automatic send_request(input frame_request_t req, input bit has_known,
                              input logic [7:0] known_byte);
    bit         gives_byte;
    logic [7:0] predicted;
    start        <= 1'b1;
    cmd          <= req.cmd;
    byte_address <= req.byte_address;
    byte_value   <= req.byte_value;
    rotate_step  <= req.rotate_step;
    // busy read here is its value just before the edge
    do @(posedge clk); while (busy);
    apply_frame_request(req, gives_byte, predicted);
    if (gives_byte) expected_read_bytes.push_back(has_known ? known_byte : predicted);
  endtask

  function automatic directed_row_t make_row(input logic [3:0] c, input logic [5:0] a,
                                             input logic [7:0] v, input logic [7:0] s,
                                             input bit k, input logic [7:0] kb);
    directed_row_t row;
    row.req.cmd          = c;
    row.req.byte_address = a;
    row.req.byte_value   = v;
    row.req.rotate_step  = s;
    row.has_known        = k;
    row.known_byte       = kb;
    return row;
  endfunction

  function automatic frame_request_t random_request();
    frame_request_t req;
    int             roll;
    roll             = $urandom_range(0, 99);
    req.byte_address = 6'($urandom_range(0, 63));
    req.byte_value   = 8'($urandom_range(0, 255));
    req.rotate_step  = 8'($urandom_range(0, 255));
    if (roll < 22)      req.cmd = CMD_WRITE;
    else if (roll < 52) req.cmd = CMD_READ;
    else if (roll < 57) begin
      req.cmd = CMD_FILL;
      // dense frames make the ring moves visible
      if ($urandom_range(0, 1)) req.byte_value = 8'hFF;
    end
    else if (roll < 95) req.cmd = 4'($urandom_range(CMD_FWD, CMD_ROTATE));
    else                req.cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    return req;
  endfunction

  // every read result is checked against the oldest waiting byte
  always @(posedge clk) begin : check_reads
    logic [7:0] want;
    if (!rst && done) begin
      if (expected_read_bytes.size() == 0) begin
        report_mismatch("read result with nothing expected", read_value, 8'h00);
      end else begin
        want = expected_read_bytes.pop_front();
        if (read_value !== want) report_mismatch("read_value", read_value, want);
      end
    end
  end

  // hard stop if the handshake hangs or results never drain
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** led_cube_frame_transform_core: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    directed_row_t  rows [$];
    frame_request_t req;
    int             gap;
    mismatch_count = 0;
    cycle_count    = 0;
    foreach (frame_image[i]) frame_image[i] = '0;
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = CMD_WRITE;
    byte_address = '0;
    byte_value   = '0;
    rotate_step  = '0;

    // directed part: reset contents, address and value extremes, every command,
    // rotation phases for all, three, one and two rings, and unused codes
    rows.push_back(make_row(CMD_READ,     6'd0,  8'h00, 8'd0,   1, 8'h00));
    rows.push_back(make_row(CMD_READ,     6'd63, 8'hFF, 8'd255, 1, 8'h00));
    rows.push_back(make_row(CMD_FILL,     6'd0,  8'hFF, 8'd0,   0, 8'h00));
    rows.push_back(make_row(CMD_READ,     6'd37, 8'h00, 8'd0,   1, 8'hFF));
    rows.push_back(make_row(CMD_WRITE,    6'd63, 8'h00, 8'd0,   0, 8'h00));
    rows.push_back(make_row(CMD_WRITE,    6'd0,  8'hA5, 8'd0,   0, 8'h00));
    rows.push_back(make_row(CMD_READ,     6'd0,  8'h00, 8'd0,   1, 8'hA5));
    rows.push_back(make_row(CMD_READ,     6'd63, 8'h00, 8'd0,   1, 8'h00));
    rows.push_back(make_row(CMD_FWD,      6'd0,  8'h00, 8'd0,   0, 8'h00));
    rows.push_back(make_row(CMD_BACK,     6'd0,  8'h00, 8'd0,   0, 8'h00));
    rows.push_back(make_row(CMD_READ,     6'd0,  8'h00, 8'd0,   1, 8'h00));
    rows.push_back(make_row(CMD_DOWN,     6'd0,  8'h00, 8'd0,   0, 8'h00));
    rows.push_back(make_row(CMD_UP,       6'd0,  8'h00, 8'd0,   0, 8'h00));
    rows.push_back(make_row(CMD_BITLEFT,  6'd0,  8'h00, 8'd0,   0, 8'h00));
    rows.push_back(make_row(CMD_READ,     6'd15, 8'h00, 8'd0,   0, 8'h00));
    rows.push_back(make_row(CMD_BITRIGHT, 6'd0,  8'h00, 8'd0,   0, 8'h00));
    rows.push_back(make_row(CMD_FILL,     6'd0,  8'h5A, 8'd0,   0, 8'h00));
    rows.push_back(make_row(CMD_WRITE,    6'd27, 8'h81, 8'd0,   0, 8'h00));
    rows.push_back(make_row(CMD_ROTATE,   6'd0,  8'h00, 8'd4,   0, 8'h00));
    rows.push_back(make_row(CMD_ROTATE,   6'd0,  8'h00, 8'd255, 0, 8'h00));
    rows.push_back(make_row(CMD_ROTATE,   6'd0,  8'h00, 8'd6,   0, 8'h00));
    rows.push_back(make_row(CMD_ROTATE,   6'd0,  8'h00, 8'd0,   0, 8'h00));
    rows.push_back(make_row(CMD_READ,     6'd27, 8'h00, 8'd0,   0, 8'h00));
    rows.push_back(make_row(CMD_UNUSED_HI, 6'd63, 8'hFF, 8'd255, 0, 8'h00));
    rows.push_back(make_row(CMD_UNUSED_LO, 6'd24, 8'h00, 8'd0,   0, 8'h00));
    rows.push_back(make_row(CMD_READ,     6'd24, 8'h00, 8'd0,   0, 8'h00));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_request(rows[i].req, rows[i].has_known, rows[i].known_byte);

    // random part: idle bursts early on, back to back at the tail
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 3 || n == RANDOM_REQUESTS / 2) begin
        // hold off until every read result has come back
        start <= 1'b0;
        do @(posedge clk); while (expected_read_bytes.size() != 0);
      end else if (n < RANDOM_REQUESTS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 3);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      req = random_request();
      send_request(req, 1'b0, 8'h00);
    end

    start <= 1'b0;
    do @(posedge clk); while (expected_read_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** led_cube_frame_transform_core: PASSED **");
    end else begin
      $display("** led_cube_frame_transform_core: FAILED **");
    end
    $finish;
  end

endmodule
